FILE: design/cosine_similarity_defines.svh
// Assertion macros shared by the cosine similarity block.
`ifndef COSINE_SIMILARITY_DEFINES_SVH
`define COSINE_SIMILARITY_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define CSIM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define CSIM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/csim_pkg.sv
// Package with the widths and types of the cosine similarity block.
package csim_pkg;
  localparam int ElemWidth = 16;
  localparam int ProdWidth = 2 * ElemWidth;
  localparam int DotWidth  = 41;
  localparam int NormWidth = 40;
  localparam int MulWidth  = 48;
  localparam int MulSteps  = MulWidth / 8;
  localparam int AccWidth  = 2 * MulWidth;
  localparam int CmpWidth  = 113;
  localparam int RootBits  = 16;

  typedef struct packed {
    logic signed [DotWidth-1:0] dot;
    logic [NormWidth-1:0]       nx;
    logic [NormWidth-1:0]       ny;
  } csim_sums_t;

  typedef struct packed {
    logic full;
    logic empty;
  } csim_fifo_st_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_ROOT = 5'b00100,
    S_SAT  = 5'b01000,
    S_OUT  = 5'b10000
  } csim_state_e;
endpackage

FILE: design/csim_front.sv
// Front part: element products and the three saturating running sums.
module csim_front (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [csim_pkg::ElemWidth-1:0]  x_elem_i,
  input  logic signed [csim_pkg::ElemWidth-1:0]  y_elem_i,
  input  logic                                   last_elem_i,
  output logic                                   push_o,
  output csim_pkg::csim_sums_t                   sums_o,
  input  csim_pkg::csim_fifo_st_t                fifo_st_i
);
  import csim_pkg::*;

  logic                          p_vld_q, p_vld_d, p_last_q;
  logic signed [ProdWidth-1:0]   pxy_q, pxx_q, pyy_q;
  logic signed [DotWidth-1:0]    dot_q, dot_d;
  logic [NormWidth-1:0]          nx_q, nx_d, ny_q, ny_d;
  logic signed [DotWidth:0]      dot_sum;
  logic [NormWidth:0]            nx_sum, ny_sum;
  logic                          blocked;
  csim_sums_t                    sums;

  assign blocked    = p_vld_q & p_last_q & fifo_st_i.full;
  assign in_stall_o = blocked;

  always_comb begin
    dot_sum = (DotWidth+1)'(dot_q) + (DotWidth+1)'(pxy_q);
    nx_sum  = {1'b0, nx_q} + (NormWidth+1)'(unsigned'(pxx_q));
    ny_sum  = {1'b0, ny_q} + (NormWidth+1)'(unsigned'(pyy_q));
    if (dot_sum[DotWidth] != dot_sum[DotWidth-1]) begin
      sums.dot = dot_sum[DotWidth] ? {1'b1, {(DotWidth-1){1'b0}}}
                                   : {1'b0, {(DotWidth-1){1'b1}}};
    end else begin
      sums.dot = dot_sum[DotWidth-1:0];
    end
    sums.nx = nx_sum[NormWidth] ? {NormWidth{1'b1}} : nx_sum[NormWidth-1:0];
    sums.ny = ny_sum[NormWidth] ? {NormWidth{1'b1}} : ny_sum[NormWidth-1:0];
  end

  assign sums_o = sums;
  assign push_o = p_vld_q & p_last_q & ~fifo_st_i.full;

  always_comb begin
    dot_d   = dot_q;
    nx_d    = nx_q;
    ny_d    = ny_q;
    p_vld_d = p_vld_q;
    if (!blocked) begin
      p_vld_d = in_valid_i;
      if (p_vld_q) begin
        if (p_last_q) begin
          dot_d = '0;
          nx_d  = '0;
          ny_d  = '0;
        end else begin
          dot_d = sums.dot;
          nx_d  = sums.nx;
          ny_d  = sums.ny;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q  <= 1'b0;
      p_last_q <= 1'b0;
      dot_q    <= '0;
      nx_q     <= '0;
      ny_q     <= '0;
    end else begin
      p_vld_q <= p_vld_d;
      dot_q   <= dot_d;
      nx_q    <= nx_d;
      ny_q    <= ny_d;
      if (!blocked && in_valid_i) begin
        p_last_q <= last_elem_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!blocked && in_valid_i) begin
      pxy_q <= x_elem_i * y_elem_i;
      pxx_q <= x_elem_i * x_elem_i;
      pyy_q <= y_elem_i * y_elem_i;
    end
  end
endmodule

FILE: design/csim_fifo.sv
// Two-entry queue of finished sums between the front and back parts.
module csim_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  csim_pkg::csim_sums_t    push_data_i,
  input  logic                    pop_i,
  output csim_pkg::csim_sums_t    pop_data_o,
  output csim_pkg::csim_fifo_st_t status_o
);
  import csim_pkg::*;

  csim_sums_t mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign status_o.full  = cnt_q[1];
  assign status_o.empty = (cnt_q == 2'd0);
  assign pop_data_o     = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule

FILE: design/csim_back.sv
// Back part: norm product, squared dot product and the bit-serial root search.
module csim_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  csim_pkg::csim_sums_t          sums_i,
  input  csim_pkg::csim_fifo_st_t       fifo_st_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [15:0]            similarity_o,
  output logic                          zero_norm_o
);
  import csim_pkg::*;

  csim_state_e           state_q, state_d;
  logic [MulWidth-1:0]   opa_q, opa_d, opb_q, opb_d, absd_q, absd_d;
  logic [AccWidth-1:0]   acc_q, acc_d, p_q, p_d;
  logic [CmpWidth-1:0]   r_q, r_d, s_q, s_d, t_q, t_d, sum1_q, sum1_d, cand;
  logic [RootBits-1:0]   mag_q, mag_d, res_q, res_d;
  logic [3:0]            bit_q, bit_d, cnt_q, cnt_d;
  logic                  sub_q, sub_d, neg_q, neg_d, zero_q, zero_d;
  logic                  out_vld_q, out_vld_d, load;
  logic signed [15:0]    sim_q;
  logic                  zn_q;
  logic [MulWidth-1:0]   dot_ext;

  assign load = (state_q == S_OUT) && (!out_vld_q || !out_stall_i);
  assign pop_o = (state_q == S_IDLE) && !fifo_st_i.empty;
  assign dot_ext = unsigned'(MulWidth'(sums_i.dot));
  assign cand = sum1_q + (CmpWidth'(p_q) << {bit_q, 1'b0});

  always_comb begin
    state_d = state_q;
    opa_d = opa_q; opb_d = opb_q; absd_d = absd_q;
    acc_d = acc_q; p_d = p_q; r_d = r_q; s_d = s_q; t_d = t_q; sum1_d = sum1_q;
    mag_d = mag_q; res_d = res_q; bit_d = bit_q; cnt_d = cnt_q;
    sub_d = sub_q; neg_d = neg_q; zero_d = zero_q;
    case (state_q)
      S_IDLE: begin
        if (!fifo_st_i.empty) begin
          neg_d  = sums_i.dot[DotWidth-1];
          absd_d = sums_i.dot[DotWidth-1] ? (~dot_ext + 1'b1) : dot_ext;
          opa_d  = MulWidth'(sums_i.nx);
          opb_d  = MulWidth'(sums_i.ny);
          acc_d  = '0;
          cnt_d  = '0;
          if (sums_i.nx == '0 || sums_i.ny == '0) begin
            zero_d  = 1'b1;
            res_d   = '0;
            state_d = S_OUT;
          end else begin
            zero_d  = 1'b0;
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        acc_d = (acc_q << 8) + AccWidth'(opa_q * opb_q[MulWidth-1 -: 8]);
        opb_d = opb_q << 8;
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'(MulSteps - 1)) begin
          p_d   = acc_d;
          acc_d = '0;
          opa_d = absd_q;
          opb_d = absd_q;
        end else if (cnt_q == 4'(2 * MulSteps - 1)) begin
          r_d     = CmpWidth'(acc_d) << 30;
          s_d     = '0;
          t_d     = '0;
          mag_d   = '0;
          bit_d   = 4'(RootBits - 1);
          sub_d   = 1'b0;
          state_d = S_ROOT;
        end
      end
      S_ROOT: begin
        if (!sub_q) begin
          sum1_d = s_q + (t_q << ({1'b0, bit_q} + 5'd1));
          sub_d  = 1'b1;
        end else begin
          sub_d = 1'b0;
          if (cand <= r_q) begin
            s_d   = cand;
            t_d   = t_q + (CmpWidth'(p_q) << bit_q);
            mag_d = mag_q | (RootBits'(1) << bit_q);
          end
          if (bit_q == 4'd0) begin
            state_d = S_SAT;
          end else begin
            bit_d = bit_q - 4'd1;
          end
        end
      end
      S_SAT: begin
        if (neg_q) begin
          res_d = (mag_q > 16'd32768) ? 16'h8000 : (~mag_q + 16'd1);
        end else begin
          res_d = (mag_q > 16'd32767) ? 16'h7fff : mag_q;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q & out_stall_i;
    if (load) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
      cnt_q     <= '0;
      bit_q     <= '0;
      sub_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      cnt_q     <= cnt_d;
      bit_q     <= bit_d;
      sub_q     <= sub_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opa_q <= opa_d; opb_q <= opb_d; absd_q <= absd_d;
    acc_q <= acc_d; p_q <= p_d; r_q <= r_d; s_q <= s_d; t_q <= t_d;
    sum1_q <= sum1_d; mag_q <= mag_d; res_q <= res_d;
    neg_q <= neg_d; zero_q <= zero_d;
    if (load) begin
      sim_q <= signed'(res_q);
      zn_q  <= zero_q;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign similarity_o = sim_q;
  assign zero_norm_o  = zn_q;
endmodule

FILE: design/cosine_similarity.sv
// Top level of the cosine similarity block.
// Element pairs are taken at one request per cycle while in_stall_o is low; the products are
// registered, then the sums. A result follows its last request after two 6-step multiplies
// on a 48x8 multiplier, then 16 root bits (a sum step and a compare step each) and saturation;
// a zero norm skips these. The back part pops only when idle; two sums may queue before it.
// Reset is asynchronous and active low; it clears the sums, the queue and the output valid.
module cosine_similarity (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [csim_pkg::ElemWidth-1:0] x_elem_i,
  input  logic signed [csim_pkg::ElemWidth-1:0] y_elem_i,
  input  logic                                  last_elem_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [15:0]                    similarity_o,
  output logic                                  zero_norm_o
);
  import csim_pkg::*;
  `include "cosine_similarity_defines.svh"

  logic          push, pop;
  csim_sums_t    push_data, pop_data;
  csim_fifo_st_t fifo_st;

  csim_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .x_elem_i, .y_elem_i, .last_elem_i,
    .push_o(push), .sums_o(push_data), .fifo_st_i(fifo_st)
  );

  csim_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(push_data), .pop_i(pop),
    .pop_data_o(pop_data), .status_o(fifo_st)
  );

  csim_back u_back (
    .clk_i, .rst_ni, .sums_i(pop_data), .fifo_st_i(fifo_st), .pop_o(pop),
    .out_valid_o, .out_stall_i, .similarity_o, .zero_norm_o
  );

  `CSIM_ASSERT_SAME(a_zero_sim, out_valid_o && zero_norm_o, similarity_o == '0, "bad zero result")
  `CSIM_ASSERT_SAME(a_fifo_st, fifo_st.full, !fifo_st.empty, "queue full and empty together")
  `CSIM_ASSERT_SAME(a_stall_full, in_stall_o, fifo_st.full, "input stalled while queue has room")
  `CSIM_ASSERT_NEXT(a_no_pop_empty, fifo_st.empty && !push, !pop || !fifo_st.empty, "empty pop")
endmodule

FILE: tb/cosine_similarity_tb.sv
// Testbench for the cosine similarity block: directed table, random vectors, scoreboard.
module cosine_similarity_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int EW = csim_pkg::ElemWidth;
  localparam longint DotHi = 64'sd1099511627775;
  localparam longint DotLo = -64'sd1099511627776;
  localparam longint NormHi = 64'sd1099511627775;

  typedef struct {
    logic signed [15:0] sim;
    logic               zn;
  } sim_res_t;

  typedef struct {
    logic signed [EW-1:0] x;
    logic signed [EW-1:0] y;
    logic                 last;
    logic                 known;
    logic signed [15:0]   sim;
    logic                 zn;
  } pair_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [EW-1:0] x_elem_i = '0;
  logic signed [EW-1:0] y_elem_i = '0;
  logic last_elem_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [15:0] similarity_o;
  logic zero_norm_o;

  cosine_similarity uut (.*);

  always #1 clk_i = ~clk_i;

  longint dot_acc, nx_acc, ny_acc;
  sim_res_t sim_q[$];
  pair_row_t rows[$];
  int errors = 0;
  int results_seen = 0;
  int vectors_sent = 0;
  int zero_seen = 0;
  bit quiet = 1'b0;
  bit hold_off = 1'b0;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic sim_res_t cosine_of(input longint d, input longint nx,
                                         input longint ny);
    sim_res_t r;
    logic [255:0] prod, rhs, cand;
    longint mag, c, ad;
    r.zn = 1'b0;
    r.sim = '0;
    if (nx == 0 || ny == 0) begin
      r.zn = 1'b1;
      return r;
    end
    ad = d < 0 ? -d : d;
    prod = 256'(nx) * 256'(ny);
    rhs = (256'(ad) * 256'(ad)) << 30;
    mag = 0;
    for (int b = 15; b >= 0; b--) begin
      c = mag | (64'sd1 << b);
      cand = 256'(c * c) * prod;
      if (cand <= rhs) mag = c;
    end
    if (d < 0) begin
      if (mag > 32768) mag = 32768;
      r.sim = 16'(-mag);
    end else begin
      if (mag > 32767) mag = 32767;
      r.sim = 16'(mag);
    end
    return r;
  endfunction

  // Accumulates one accepted request and queues a result on the last pair.
  task automatic accumulate_pair(input logic signed [EW-1:0] x, input logic signed [EW-1:0] y,
                                 input logic last);
    longint xv, yv;
    xv = x;
    yv = y;
    dot_acc += xv * yv;
    if (dot_acc > DotHi) dot_acc = DotHi;
    if (dot_acc < DotLo) dot_acc = DotLo;
    nx_acc += xv * xv;
    if (nx_acc > NormHi) nx_acc = NormHi;
    ny_acc += yv * yv;
    if (ny_acc > NormHi) ny_acc = NormHi;
    if (last) begin
      sim_q.insert(sim_q.size(), cosine_of(dot_acc, nx_acc, ny_acc));
      dot_acc = 0;
      nx_acc = 0;
      ny_acc = 0;
      vectors_sent++;
    end
  endtask

  task automatic send_pair(input logic signed [EW-1:0] x, input logic signed [EW-1:0] y,
                           input logic last, input bit may_idle);
    if (may_idle && !quiet) begin
      while ($urandom_range(99) < 32) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    x_elem_i <= x;
    y_elem_i <= y;
    last_elem_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    accumulate_pair(x, y, last);
    @(negedge clk_i);
  endtask

  function automatic logic signed [EW-1:0] rand_elem();
    case ($urandom_range(5))
      0: return EW'(-32768);
      1: return EW'(32767);
      2: return EW'($urandom_range(255)) - EW'(128);
      default: return EW'($urandom);
    endcase
  endfunction

  task automatic add_row(input int x, input int y, input bit last, input bit known = 0,
                         input int sim = 0, input bit zn = 0);
    pair_row_t r;
    r.x = EW'(x);
    r.y = EW'(y);
    r.last = last;
    r.known = known;
    r.sim = 16'(sim);
    r.zn = zn;
    rows.insert(rows.size(), r);
  endtask

  // Result checker: the typed-in table values go on their own queue beside the predictions.
  sim_res_t typed_q[$];
  bit typed_used[$];

  always @(posedge clk_i) begin
    sim_res_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (zero_norm_o) zero_seen++;
      if (sim_q.size() == 0) begin
        report("unexpected result", similarity_o, 0);
      end else begin
        w = sim_q.pop_front();
        if (similarity_o !== w.sim) report("similarity", similarity_o, w.sim);
        if (zero_norm_o !== w.zn) report("zero_norm", zero_norm_o, w.zn);
        if (typed_used.size() > 0) begin
          if (typed_used.pop_front()) begin
            w = typed_q.pop_front();
            if (similarity_o !== w.sim) report("table similarity", similarity_o, w.sim);
            if (zero_norm_o !== w.zn) report("table zero_norm", zero_norm_o, w.zn);
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_off) out_stall_i <= 1'b1;
    else if (quiet) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(99) < 32);
  end

  initial begin
    #2000000;
    $display("FAIL cosine_similarity");
    $finish;
  end

  initial begin
    int len, n;
    sim_res_t t;
    dot_acc = 0;
    nx_acc = 0;
    ny_acc = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    add_row(0, 0, 1, 1, 0, 1);
    add_row(0, 5, 1, 1, 0, 1);
    add_row(7, 0, 1, 1, 0, 1);
    add_row(2048, 2048, 1, 1, 32767, 0);
    add_row(2048, -2048, 1, 1, -32768, 0);
    add_row(-32768, -32768, 1, 1, 32767, 0);
    add_row(32767, -32768, 1, 1, -32768, 0);
    add_row(1000, 0, 0);
    add_row(0, 1000, 1, 1, 0, 0);
    add_row(3, 4, 0);
    add_row(4, -3, 0);
    add_row(-1, 2, 1);
    add_row(32767, 32767, 0);
    add_row(-32768, 12345, 0);
    add_row(-1, -1, 1);
    foreach (rows[i]) begin
      if (rows[i].last) begin
        typed_used.insert(typed_used.size(), rows[i].known);
        if (rows[i].known) begin
          t.sim = rows[i].sim;
          t.zn = rows[i].zn;
          typed_q.insert(typed_q.size(), t);
        end
      end
      send_pair(rows[i].x, rows[i].y, rows[i].last, 1);
    end
    in_valid_i <= 1'b0;

    n = 0;
    while (n < 385) begin
      if (vectors_sent == 12) quiet = 1'b1;
      if (vectors_sent == 20) quiet = 1'b0;
      if (vectors_sent == 30 && !hold_off && n < 250) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (400) @(negedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      if (vectors_sent == 45) begin
        in_valid_i <= 1'b0;
        while (sim_q.size() != 0) @(negedge clk_i);
      end
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(6, 1);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(19) == 0)
          send_pair(0, rand_elem(), k == len - 1, 1);
        else
          send_pair(rand_elem(), rand_elem(), k == len - 1, 1);
        n++;
      end
    end
    in_valid_i <= 1'b0;

    n = 0;
    while (sim_q.size() != 0 && n < 20000) begin
      @(negedge clk_i);
      n++;
    end
    repeat (200) @(negedge clk_i);
    $display("Sent %0d vectors, checked %0d results, %0d with zero norm.",
             vectors_sent, results_seen, zero_seen);
    $display("Covered extremes, zero norms, long stalls and a drained pause.");
    if (errors == 0 && sim_q.size() == 0) begin
      $display("PASS cosine_similarity");
    end else begin
      $display("FAIL cosine_similarity");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+design
design/csim_pkg.sv
design/csim_front.sv
design/csim_fifo.sv
design/csim_back.sv
design/cosine_similarity.sv
tb/cosine_similarity_tb.sv
